// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL; clocked on clk, held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LRCA_ASSERT_IMP(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("lrca assertion failed");

// next-cycle implication
`define LRCA_ASSERT_NXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("lrca assertion failed");

`endif

// ===== rtl/lrca_pkg.sv =====
// ----------------------------------------------------------------------------
// lrca_pkg
// Item types and codes of the refcount eviction allocator.
// ----------------------------------------------------------------------------
package lrca_pkg;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_ALLOC = 1'b1;

  localparam logic [1:0] KIND_EVICT   = 2'd0;
  localparam logic [1:0] KIND_ALLOC   = 2'd1;
  localparam logic [1:0] KIND_NOSPACE = 2'd2;

  typedef struct packed {
    logic        cmd;
    logic [4:0]  slot_index;
    logic        slot_valid;
    logic [15:0] slot_key;
    logic [31:0] slot_refcount;
    logic [5:0]  need_slots;
  } req_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [4:0] run_start;
    logic [5:0] run_length;
    logic [4:0] alloc_start;
    logic       last;
  } rsp_item_t;

endpackage

// ===== rtl/lrca_if.sv =====
// ----------------------------------------------------------------------------
// lrca_req_if / lrca_rsp_if
// Valid/ready channels carrying request and result items.
// ----------------------------------------------------------------------------
interface lrca_req_if;
  logic                valid;
  logic                ready;
  lrca_pkg::req_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lrca_rsp_if;
  logic                valid;
  logic                ready;
  lrca_pkg::rsp_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/lrca_ram.sv =====
// ----------------------------------------------------------------------------
// lrca_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lrca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/least_refcount_contiguous_alloc.sv =====
// A load item gives no result. An allocate item first splits runs in one bucket
// walk, then per eviction runs a window scan, a count scan, a run walk and an
// emit step; input is held off until the last result is in the output reg.
// Throughput is set by the single read port of the key and count RAMs.
// Reset (synchronous): no slot valid, slots_in_use = 32, no result pending.
// ----------------------------------------------------------------------------
// least_refcount_contiguous_alloc
// Evicts runs of equal-key slots in rising refcount order until a contiguous
// free window of the asked length exists, or no run is left to evict.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module least_refcount_contiguous_alloc #(
  parameter int SLOTS      = 32,
  parameter int KEY_BITS   = 16,
  parameter int COUNT_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  lrca_req_if.sink    req,
  lrca_rsp_if.source  rsp
);

  localparam int IW = $clog2(SLOTS);     // slot index
  localparam int CW = $clog2(SLOTS + 1); // slot count / walk pointer

  typedef enum logic [2:0] {
    ST_IDLE, ST_SPLIT, ST_WIN, ST_MIN, ST_EV_KEY, ST_EV_CAP, ST_EV_WALK, ST_EMIT
  } state_t;

  state_t              state;
  logic [5:0]          slots_in_use;
  logic [CW-1:0]       n_slots;
  logic [5:0]          need;
  logic [CW-1:0]       ptr;
  logic                rd_v;        // a RAM read is in flight
  logic [IW-1:0]       rd_idx;      // slot of that read
  logic [KEY_BITS-1:0] prev_key;
  logic [SLOTS-1:0]    valid_bits;
  logic [SLOTS-1:0]    is_start;
  logic [SLOTS-1:0]    done_mark;
  logic [CW-1:0]       run_cnt;
  logic                have;
  logic [IW-1:0]       best;
  logic [COUNT_BITS-1:0] best_cnt;
  logic [KEY_BITS-1:0] ekey;
  logic [CW-1:0]       elen;
  lrca_pkg::rsp_item_t pend;
  lrca_pkg::rsp_item_t out_item;
  logic                out_valid;

  logic [KEY_BITS-1:0]   key_rd;
  logic [COUNT_BITS-1:0] cnt_rd;
  logic [IW-1:0]         raddr;
  logic [IW-1:0]         widx;
  logic                  in_range;
  logic                  load_we;
  logic [CW-1:0]         n_eff;
  logic [CW-1:0]         win_start;
  logic                  scan_end;
  logic                  ev_stop;
  logic                  out_is_evict;
  logic                  load_v;

  // --------------------------------------------------------------------------
  // handshake and combinational helpers
  // --------------------------------------------------------------------------
  assign req.ready = (state == ST_IDLE);
  assign rsp.valid = out_valid;
  assign rsp.data  = out_item;

  assign widx     = IW'(req.data.slot_index);
  assign in_range = 32'(req.data.slot_index) < SLOTS;
  assign load_we  = req.valid && req.ready && (req.data.cmd == lrca_pkg::CMD_LOAD)
                    && in_range;
  assign n_eff    = (32'(slots_in_use) > SLOTS) ? CW'(SLOTS) : CW'(slots_in_use);
  assign win_start = CW'(32'(ptr) + 1 - 32'(need));
  assign raddr    = (state == ST_EV_KEY) ? best : ptr[IW-1:0];
  // a streaming scan is over once the pointer is past the end and nothing is
  // left in flight
  assign scan_end = (ptr >= n_slots) && !rd_v;
  // run walk stops at a freed slot or a key change
  assign ev_stop  = rd_v && !(valid_bits[rd_idx] && key_rd == ekey);
  assign out_is_evict = (out_item.result_kind == lrca_pkg::KIND_EVICT);
  assign load_v       = req.data.slot_valid;

  // key and count store: written by loads, read one slot a cycle by the walks
  lrca_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (widx),
    .wdata (KEY_BITS'(req.data.slot_key)),
    .raddr (raddr),
    .rdata (key_rd)
  );

  lrca_ram #(.WIDTH(COUNT_BITS), .DEPTH(SLOTS)) u_cnt_ram (
    .clk   (clk),
    .we    (load_we),
    .waddr (widx),
    .wdata (COUNT_BITS'(req.data.slot_refcount)),
    .raddr (raddr),
    .rdata (cnt_rd)
  );

  // --------------------------------------------------------------------------
  // sequencer
  //   SPLIT   : mark run starts from key of slot and its left neighbour
  //   WIN     : look for a free window, one slot a cycle
  //   MIN     : pick the unevicted run with the lowest first-slot count
  //   EV_*    : clear the chosen run while the key still matches
  //   EMIT    : hand the item to the output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      slots_in_use <= 6'd32;
      valid_bits   <= '0;
      done_mark    <= '0;
      is_start     <= '0;
      out_valid    <= 1'b0;
      rd_v         <= 1'b0;
      have         <= 1'b0;
    end else begin
      if (cfg_we) begin
        slots_in_use <= cfg_wdata;
      end
      // EMIT owns the output register in its own state
      if (rsp.ready && state != ST_EMIT) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (req.valid) begin
            if (req.data.cmd == lrca_pkg::CMD_LOAD) begin
              if (in_range) begin
                valid_bits[widx] <= req.data.slot_valid;
              end
            end else begin
              n_slots   <= n_eff;
              need      <= req.data.need_slots;
              ptr       <= '0;
              rd_v      <= 1'b0;
              is_start  <= '0;
              done_mark <= '0;
              state     <= ST_SPLIT;
            end
          end
        end

        ST_SPLIT: begin
          if (rd_v) begin
            is_start[rd_idx] <= valid_bits[rd_idx] &&
                                (rd_idx == '0 || !valid_bits[rd_idx - 1'b1] ||
                                 prev_key != key_rd);
            prev_key <= key_rd;
          end
          if (ptr < n_slots) begin
            ptr    <= ptr + 1'b1;
            rd_v   <= 1'b1;
            rd_idx <= ptr[IW-1:0];
          end else begin
            rd_v <= 1'b0;
            if (!rd_v) begin
              ptr     <= '0;
              run_cnt <= '0;
              state   <= ST_WIN;
            end
          end
        end

        ST_WIN: begin
          if (need == '0) begin
            pend  <= '{lrca_pkg::KIND_ALLOC, 5'd0, 6'd0, 5'd0, 1'b1};
            state <= ST_EMIT;
          end else if (ptr >= n_slots) begin
            ptr   <= '0;
            rd_v  <= 1'b0;
            have  <= 1'b0;
            state <= ST_MIN;
          end else begin
            if (!valid_bits[ptr[IW-1:0]]) begin
              if (32'(run_cnt) + 1 >= 32'(need)) begin
                pend  <= '{lrca_pkg::KIND_ALLOC, 5'd0, 6'd0, 5'(win_start), 1'b1};
                state <= ST_EMIT;
              end else begin
                run_cnt <= run_cnt + 1'b1;
              end
            end else begin
              run_cnt <= '0;
            end
            ptr <= ptr + 1'b1;
          end
        end

        ST_MIN: begin
          if (rd_v && is_start[rd_idx] && !done_mark[rd_idx] &&
              (!have || cnt_rd < best_cnt)) begin
            best     <= rd_idx;
            best_cnt <= cnt_rd;
            have     <= 1'b1;
          end
          if (ptr < n_slots) begin
            ptr    <= ptr + 1'b1;
            rd_v   <= 1'b1;
            rd_idx <= ptr[IW-1:0];
          end else begin
            rd_v <= 1'b0;
            if (scan_end) begin
              if (!have) begin
                pend  <= '{lrca_pkg::KIND_NOSPACE, 5'd0, 6'd0, 5'd0, 1'b1};
                state <= ST_EMIT;
              end else begin
                done_mark[best]  <= 1'b1;
                valid_bits[best] <= 1'b0;
                elen             <= CW'(1);
                ptr              <= CW'(best) + 1'b1;
                state            <= ST_EV_KEY;
              end
            end
          end
        end

        ST_EV_KEY: begin
          state <= ST_EV_CAP;
        end

        ST_EV_CAP: begin
          ekey  <= key_rd;
          rd_v  <= 1'b0;
          state <= ST_EV_WALK;
        end

        ST_EV_WALK: begin
          if (ev_stop || scan_end) begin
            rd_v  <= 1'b0;
            pend  <= '{lrca_pkg::KIND_EVICT, 5'(best), 6'(elen), 5'd0, 1'b0};
            state <= ST_EMIT;
          end else begin
            if (rd_v) begin
              valid_bits[rd_idx] <= 1'b0;
              elen               <= elen + 1'b1;
            end
            if (ptr < n_slots) begin
              ptr    <= ptr + 1'b1;
              rd_v   <= 1'b1;
              rd_idx <= ptr[IW-1:0];
            end else begin
              rd_v <= 1'b0;
            end
          end
        end

        ST_EMIT: begin
          if (!out_valid || rsp.ready) begin
            out_item  <= pend;
            out_valid <= 1'b1;
            ptr       <= '0;
            run_cnt   <= '0;
            state     <= pend.last ? ST_IDLE : ST_WIN;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `LRCA_ASSERT_IMP(a_nonlast_is_evict, out_valid && !out_item.last, out_is_evict)
  `LRCA_ASSERT_IMP(a_evict_nonempty, out_valid && out_is_evict, out_item.run_length != 6'd0)
  `LRCA_ASSERT_NXT(a_load_sets_valid, load_we, valid_bits[$past(widx)] == $past(load_v))

endmodule

// ===== dv/lrca_tb_if.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lrca_tb_if
// Testbench copy point for the request and result channels; the RTL
// interfaces are instantiated directly, so this file only holds shared types.
// ----------------------------------------------------------------------------
package lrca_tb_pkg;

  // one expected result item
  typedef lrca_pkg::rsp_item_t exp_item_t;
endpackage

// ===== dv/tb_least_refcount_contiguous_alloc.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_least_refcount_contiguous_alloc
// Drives slot loads and allocate requests into the refcount eviction
// allocator, predicts each eviction and final result, and checks them in order.
// ----------------------------------------------------------------------------
module tb_least_refcount_contiguous_alloc;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [5:0] cfg_wdata;

  lrca_req_if req ();
  lrca_rsp_if rsp ();

  least_refcount_contiguous_alloc dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .req(req.sink), .rsp(rsp.source)
  );

  // mirror of the bucket
  logic        bkt_valid [32];
  logic [15:0] bkt_key   [32];
  logic [31:0] bkt_count [32];
  logic [5:0]  slots_cfg;

  lrca_tb_pkg::exp_item_t expected_q[$];
  int  errors;
  int  cycles;
  bit  idle_on;     // random idling enabled
  bit  rsp_hold;    // long receiver hold-off
  int  hold_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit: covers an allocate that evicts every run, plus stalls
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 2000000) begin
      $display("[least_refcount_contiguous_alloc] ERROR");
      $finish;
    end
  end

  // predict the results of one allocate, updating the mirror
  function automatic bit window_at(int n, int need, output int start);
    int run;
    run = 0;
    start = 0;
    if (need == 0) return 1'b1;
    for (int i = 0; i < n; i++) begin
      if (!bkt_valid[i]) begin
        run++;
        if (run >= need) begin
          start = i + 1 - need;
          return 1'b1;
        end
      end else begin
        run = 0;
      end
    end
    return 1'b0;
  endfunction

  task automatic predict_alloc(input logic [5:0] need);
    int n, i, s, st, best;
    bit have;
    bit starts [32];
    bit done   [32];
    int len    [32];
    lrca_tb_pkg::exp_item_t r;
    n = (slots_cfg > 32) ? 32 : slots_cfg;
    for (int j = 0; j < 32; j++) begin
      starts[j] = 0;
      done[j] = 0;
      len[j] = 0;
    end
    // split valid slots into equal-key runs
    i = 0;
    while (i < n) begin
      if (!bkt_valid[i]) begin
        i++;
      end else begin
        s = i;
        while (i < n && bkt_valid[i] && bkt_key[i] == bkt_key[s]) i++;
        starts[s] = 1;
        len[s] = i - s;
      end
    end
    forever begin
      r = '0;
      if (window_at(n, need, st)) begin
        r.result_kind = lrca_pkg::KIND_ALLOC;
        r.alloc_start = st[4:0];
        r.last = 1'b1;
        expected_q.push_back(r);
        return;
      end
      have = 0;
      best = 0;
      for (int j = 0; j < n; j++)
        if (starts[j] && !done[j] && (!have || bkt_count[j] < bkt_count[best])) begin
          best = j;
          have = 1;
        end
      if (!have) begin
        r.result_kind = lrca_pkg::KIND_NOSPACE;
        r.last = 1'b1;
        expected_q.push_back(r);
        return;
      end
      done[best] = 1;
      for (int j = best; j < best + len[best] && j < n; j++) bkt_valid[j] = 1'b0;
      r.result_kind = lrca_pkg::KIND_EVICT;
      r.run_start = best[4:0];
      r.run_length = len[best][5:0];
      expected_q.push_back(r);
    end
  endtask

  // send one item; prediction is made at acceptance; valid stays up so that
  // the next item can follow back to back
  task automatic send_item(input lrca_pkg::req_item_t it);
    if (idle_on) begin
      while ($urandom_range(99) < 33) begin
        req.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req.valid <= 1'b1;
    req.data  <= it;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (it.cmd == lrca_pkg::CMD_LOAD) begin
      bkt_valid[it.slot_index] = it.slot_valid;
      bkt_key[it.slot_index]   = it.slot_key;
      bkt_count[it.slot_index] = it.slot_refcount;
    end else begin
      predict_alloc(it.need_slots);
    end
  endtask

  task automatic load_slot(input int idx, input bit v, input logic [15:0] k,
                           input logic [31:0] c);
    lrca_pkg::req_item_t it;
    it = '0;
    it.cmd = lrca_pkg::CMD_LOAD;
    it.slot_index = idx[4:0];
    it.slot_valid = v;
    it.slot_key = k;
    it.slot_refcount = c;
    send_item(it);
  endtask

  task automatic alloc(input int need);
    lrca_pkg::req_item_t it;
    it = '0;
    it.cmd = lrca_pkg::CMD_ALLOC;
    it.need_slots = need[5:0];
    send_item(it);
  endtask

  // stop sending, wait for all results, then the block's tail latency
  task automatic drain();
    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_slots(input logic [5:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    slots_cfg = v;
  endtask

  // result receiver: random stalls and a long hold-off
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (rsp_hold) begin
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= !idle_on || ($urandom_range(99) >= 33);
    end
  end

  always @(posedge clk) begin
    if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    rsp_hold <= (hold_cycles > 1);
  end

  // checker
  always @(posedge clk) begin
    lrca_tb_pkg::exp_item_t e;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, rsp.data);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (rsp.data.result_kind !== e.result_kind || rsp.data.run_start !== e.run_start
            || rsp.data.run_length !== e.run_length
            || rsp.data.alloc_start !== e.alloc_start || rsp.data.last !== e.last) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, rsp.data);
          errors++;
        end
      end
    end
  end

  // fill the bucket with runs of random keys from a small set
  task automatic fill_bucket(input int nslots);
    for (int i = 0; i < nslots; i++)
      load_slot(i, $urandom_range(99) < 85, 16'($urandom_range(3)),
                ($urandom_range(3) == 0) ? $urandom() : 32'($urandom_range(7)));
  endtask

  task automatic test_directed();
    for (int i = 0; i < 8; i++) load_slot(i, 1'b1, 16'hFFFF, 32'hFFFF_FFFF);
    load_slot(8, 1'b1, 16'h0000, 32'h0);
    load_slot(9, 1'b0, 16'h1234, 32'h5);
    load_slot(31, 1'b1, 16'h0001, 32'h0);
    alloc(0);                 // zero asked: slot 0 at once
    alloc(33);                // above slots in use: evict all, no space
    load_slot(0, 1'b1, 16'h5, 32'h3);
    load_slot(1, 1'b1, 16'h5, 32'h1); // count from run head only
    load_slot(2, 1'b1, 16'h6, 32'h3); // tie with slot 0
    alloc(32);
    load_slot(4, 1'b1, 16'hAAAA, 32'h8000_0000);
    alloc(1);
    alloc(63);
  endtask

  task automatic test_config();
    logic [5:0] vals [6] = '{6'd1, 6'd32, 6'd63, 6'd0, 6'd5, 6'd32};
    foreach (vals[i]) begin
      write_slots(vals[i]);
      fill_bucket(32);
      alloc($urandom_range(6));
      alloc(33);
    end
  endtask

  task automatic test_backpressure();
    // receiver holds off; sender keeps offering
    fill_bucket(32);
    hold_cycles = 300;
    alloc(20);
    alloc(3);
    load_slot(1, 1'b1, 16'h1, 32'h1);
    drain();  // sender pause until everything is back
  endtask

  task automatic test_random(input int items);
    for (int k = 0; k < items; k++) begin
      idle_on = !(k >= 100 && k < 200);
      if ($urandom_range(99) < 70) begin
        load_slot($urandom_range(31), $urandom_range(99) < 80, 16'($urandom_range(3)),
                  ($urandom_range(4) == 0) ? $urandom() : 32'($urandom_range(15)));
      end else if ($urandom_range(9) == 0) begin
        alloc($urandom_range(63));
      end else begin
        alloc($urandom_range(8));
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req.valid = 1'b0;
    req.data = '0;
    errors = 0;
    cycles = 0;
    idle_on = 1'b1;
    hold_cycles = 0;
    slots_cfg = 6'd32;
    for (int i = 0; i < 32; i++) begin
      bkt_valid[i] = 1'b0;
      bkt_key[i] = '0;
      bkt_count[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config();
    test_backpressure();
    test_random(250);
    drain();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("[least_refcount_contiguous_alloc] OK");
    end else begin
      $display("[least_refcount_contiguous_alloc] ERROR");
    end
    $finish;
  end

endmodule
